// File: design/lpdk_pkg.sv
// Package: types, codes and reset values for the length-prefix deframer with keepalive.
package lpdk_pkg;

   localparam int unsigned CAP_WIDTH   = 17;
   localparam int unsigned CODE_WIDTH  = 8;
   localparam int unsigned LIMIT_WIDTH = 32;
   localparam int unsigned LEN_WIDTH   = 16;
   localparam int unsigned CSR_WIDTH   = 32;
   localparam int unsigned CSR_IDX_WIDTH = 3;

   localparam logic [CAP_WIDTH-1:0]   CAP_RESET       = 17'd4096;
   localparam logic [CODE_WIDTH-1:0]  PING_RESET      = 8'd1;
   localparam logic [CODE_WIDTH-1:0]  PONG_RESET      = 8'd2;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 32'd0;
   localparam logic [CAP_WIDTH-1:0]   LEN_HEADER_SIZE = 17'd2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_BUFFER_CAPACITY = 3'd0,
      CSR_PING_CODE       = 3'd1,
      CSR_PONG_CODE       = 3'd2,
      CSR_IDLE_LIMIT      = 3'd3,
      CSR_KEEPALIVE_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_TICK    = 2'd1,
      OP_SENT    = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD  = 3'd0,
      KIND_PING     = 3'd1,
      KIND_PONG     = 3'd2,
      KIND_OVERSIZE = 3'd3,
      KIND_IDLE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_LEN_HI = 2'd0,
      PH_LEN_LO = 2'd1,
      PH_CTRL   = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]           out_kind;
      logic [7:0]           out_byte;
      logic                 frame_last;
      logic [LEN_WIDTH-1:0] frame_length;
   } rsp_type;

endpackage

// File: design/length_prefix_deframer_keepalive.sv
// Top level: length-prefixed stream deframer with idle timeout and keepalive ping.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_data  (opcode, rx_byte)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data  (out_kind, out_byte,
//           |           |                        |            frame_last, frame_length)
//   csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// One item per clock. The parser and tick counters update at the accepting edge and
// any result lands in the result register, visible in the cycle after the transfer.
// req_ready drops only while the result register is full and rsp_ready is low.
// Synchronous reset restores register defaults and clears all state but the result data; no clearing pass.
module length_prefix_deframer_keepalive (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  lpdk_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output lpdk_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_we,
   input  logic [lpdk_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [lpdk_pkg::CSR_WIDTH-1:0]           csr_wdata
);

   logic [lpdk_pkg::CAP_WIDTH-1:0]   capacity_ff;
   logic [lpdk_pkg::CODE_WIDTH-1:0]  ping_code_ff;
   logic [lpdk_pkg::CODE_WIDTH-1:0]  pong_code_ff;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] idle_limit_ff;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] keepalive_limit_ff;

   lpdk_pkg::phase_type              parse_phase_ff, parse_phase_in;
   logic [7:0]                       length_high_ff, length_high_in;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   frame_len_ff, frame_len_in;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   bytes_left_ff, bytes_left_in;
   logic                             link_closed_ff, link_closed_in;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] idle_ticks_ff, idle_ticks_in;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] send_ticks_ff, send_ticks_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   lpdk_pkg::rsp_type                rsp_data_ff;

   logic                             req_fire;
   logic                             active;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   len_word;
   logic                             oversize;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   bytes_dec;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] idle_inc;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] send_inc;
   logic                             idle_expired;
   logic                             ping_due;
   logic                             ping_match;
   logic                             res_valid;
   lpdk_pkg::rsp_type                res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign active    = req_fire && !link_closed_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign len_word   = {length_high_ff, req_data.rx_byte};
   assign oversize   = ({1'b0, len_word} + lpdk_pkg::LEN_HEADER_SIZE) > capacity_ff;
   assign bytes_dec  = bytes_left_ff - 16'd1;
   assign idle_inc   = (&idle_ticks_ff) ? idle_ticks_ff : idle_ticks_ff + 32'd1;
   assign send_inc   = (&send_ticks_ff) ? send_ticks_ff : send_ticks_ff + 32'd1;
   assign idle_expired = (idle_limit_ff != '0) && (idle_inc > idle_limit_ff);
   assign ping_due     = (keepalive_limit_ff != '0) && (send_inc > keepalive_limit_ff);
   assign ping_match   = (req_data.rx_byte == ping_code_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff        <= lpdk_pkg::CAP_RESET;
         ping_code_ff       <= lpdk_pkg::PING_RESET;
         pong_code_ff       <= lpdk_pkg::PONG_RESET;
         idle_limit_ff      <= lpdk_pkg::LIMIT_RESET;
         keepalive_limit_ff <= lpdk_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lpdk_pkg::CSR_BUFFER_CAPACITY: capacity_ff <= csr_wdata[lpdk_pkg::CAP_WIDTH-1:0];
            lpdk_pkg::CSR_PING_CODE:       ping_code_ff <= csr_wdata[lpdk_pkg::CODE_WIDTH-1:0];
            lpdk_pkg::CSR_PONG_CODE:       pong_code_ff <= csr_wdata[lpdk_pkg::CODE_WIDTH-1:0];
            lpdk_pkg::CSR_IDLE_LIMIT:      idle_limit_ff <= csr_wdata;
            lpdk_pkg::CSR_KEEPALIVE_LIMIT: keepalive_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      parse_phase_in = parse_phase_ff;
      length_high_in = length_high_ff;
      frame_len_in   = frame_len_ff;
      bytes_left_in  = bytes_left_ff;
      link_closed_in = link_closed_ff;
      idle_ticks_in  = idle_ticks_ff;
      send_ticks_in  = send_ticks_ff;
      if (active) begin
         case (req_data.opcode)
            lpdk_pkg::OP_RX_BYTE: begin
               idle_ticks_in = '0;
               case (parse_phase_ff)
                  lpdk_pkg::PH_LEN_HI: begin
                     length_high_in = req_data.rx_byte;
                     parse_phase_in = lpdk_pkg::PH_LEN_LO;
                  end
                  lpdk_pkg::PH_LEN_LO: begin
                     if (oversize) begin
                        link_closed_in = 1'b1;
                        parse_phase_in = lpdk_pkg::PH_LEN_HI;
                     end else if (len_word == '0) begin
                        parse_phase_in = lpdk_pkg::PH_CTRL;
                     end else begin
                        frame_len_in   = len_word;
                        bytes_left_in  = len_word;
                        parse_phase_in = lpdk_pkg::PH_BODY;
                     end
                  end
                  lpdk_pkg::PH_CTRL: begin
                     parse_phase_in = lpdk_pkg::PH_LEN_HI;
                     if (ping_match) begin
                        send_ticks_in = '0;
                     end
                  end
                  default: begin
                     bytes_left_in = bytes_dec;
                     if (bytes_dec == '0) begin
                        parse_phase_in = lpdk_pkg::PH_LEN_HI;
                     end
                  end
               endcase
            end
            lpdk_pkg::OP_TICK: begin
               idle_ticks_in = idle_inc;
               send_ticks_in = send_inc;
               if (idle_expired) begin
                  link_closed_in = 1'b1;
               end else if (ping_due) begin
                  send_ticks_in = '0;
               end
            end
            lpdk_pkg::OP_SENT: begin
               send_ticks_in = '0;
            end
            default: ;
         endcase
      end
   end

   // result
   always_comb begin
      res_valid        = 1'b0;
      res.out_kind     = lpdk_pkg::KIND_PAYLOAD;
      res.out_byte     = '0;
      res.frame_last   = 1'b0;
      res.frame_length = '0;
      case (req_data.opcode)
         lpdk_pkg::OP_RX_BYTE: begin
            case (parse_phase_ff)
               lpdk_pkg::PH_LEN_LO: begin
                  if (oversize) begin
                     res_valid        = 1'b1;
                     res.out_kind     = lpdk_pkg::KIND_OVERSIZE;
                     res.frame_length = len_word;
                  end
               end
               lpdk_pkg::PH_CTRL: begin
                  if (ping_match) begin
                     res_valid    = 1'b1;
                     res.out_kind = lpdk_pkg::KIND_PONG;
                     res.out_byte = pong_code_ff;
                  end
               end
               lpdk_pkg::PH_BODY: begin
                  res_valid        = 1'b1;
                  res.out_kind     = lpdk_pkg::KIND_PAYLOAD;
                  res.out_byte     = req_data.rx_byte;
                  res.frame_last   = (bytes_dec == '0);
                  res.frame_length = frame_len_ff;
               end
               default: ;
            endcase
         end
         lpdk_pkg::OP_TICK: begin
            if (idle_expired) begin
               res_valid    = 1'b1;
               res.out_kind = lpdk_pkg::KIND_IDLE;
            end else if (ping_due) begin
               res_valid    = 1'b1;
               res.out_kind = lpdk_pkg::KIND_PING;
               res.out_byte = ping_code_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (active && res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff <= lpdk_pkg::PH_LEN_HI;
         length_high_ff <= '0;
         frame_len_ff   <= '0;
         bytes_left_ff  <= '0;
         link_closed_ff <= 1'b0;
         idle_ticks_ff  <= '0;
         send_ticks_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         parse_phase_ff <= parse_phase_in;
         length_high_ff <= length_high_in;
         frame_len_ff   <= frame_len_in;
         bytes_left_ff  <= bytes_left_in;
         link_closed_ff <= link_closed_in;
         idle_ticks_ff  <= idle_ticks_in;
         send_ticks_ff  <= send_ticks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (active && res_valid) begin
         rsp_data_ff <= res;
      end
   end

`ifndef SYNTHESIS
   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      parse_phase_ff == lpdk_pkg::PH_BODY |-> bytes_left_ff != '0)
      else $error("body phase with no bytes left");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      link_closed_ff |=> link_closed_ff)
      else $error("closed link reopened without reset");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      active && res_valid && res.out_kind == lpdk_pkg::KIND_PAYLOAD && res.frame_last
      |=> parse_phase_ff == lpdk_pkg::PH_LEN_HI)
      else $error("last payload byte did not end the frame");

   a_close_result_closes: assert property (@(posedge clock) disable iff (reset)
      active && res_valid && (res.out_kind == lpdk_pkg::KIND_OVERSIZE ||
                              res.out_kind == lpdk_pkg::KIND_IDLE)
      |=> link_closed_ff)
      else $error("close result without closing the link");
`endif

endmodule

// File: verif/length_prefix_deframer_keepalive_tb.sv
// Testbench for the length-prefix deframer: directed table plus random framed traffic.
`timescale 1ns / 100ps

module length_prefix_deframer_keepalive_tb;

   localparam logic [1:0]                         OP_UNUSED     = 2'd3;
   localparam logic [lpdk_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE_LO  = 3'd5;
   localparam logic [lpdk_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE_HI  = 3'd7;
   localparam int unsigned                        NUM_STEPS     = 23;
   localparam int unsigned                        PHASE_ITEMS   = 70;
   localparam int unsigned                        NUM_PHASES    = 8;
   localparam int unsigned                        HOLD_CYCLES   = 80;
   localparam int unsigned                        SETTLE_CYCLES = 4;
   localparam int unsigned                        CYCLE_LIMIT   = 400000;
   localparam lpdk_pkg::rsp_type                  NO_RSP        = '0;

   typedef enum {GEN_NORMAL, GEN_CLOSE_IDLE, GEN_CLOSE_OVERSIZE} gen_mode_type;

   typedef struct {
      lpdk_pkg::req_type item;
      bit                fixed;
      bit                fixed_has;
      lpdk_pkg::rsp_type fixed_rsp;
   } step_row_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   lpdk_pkg::req_type                  req_data;
   logic                               rsp_valid;
   logic                               rsp_ready;
   lpdk_pkg::rsp_type                  rsp_data;
   logic                               csr_we;
   logic [lpdk_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [lpdk_pkg::CSR_WIDTH-1:0]     csr_wdata;

   // deframer copy: registers and parse state
   logic [lpdk_pkg::CAP_WIDTH-1:0]   cap_reg;
   logic [lpdk_pkg::CODE_WIDTH-1:0]  ping_reg;
   logic [lpdk_pkg::CODE_WIDTH-1:0]  pong_reg;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] idle_limit_reg;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] keepalive_limit_reg;
   lpdk_pkg::phase_type              rx_phase;
   logic [7:0]                       len_high_byte;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   cur_frame_len;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   body_left;
   bit                               link_down;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] idle_count;
   logic [lpdk_pkg::LIMIT_WIDTH-1:0] send_count;
   logic [lpdk_pkg::LEN_WIDTH-1:0]   plan_len;

   lpdk_pkg::rsp_type awaited_outputs[$];
   step_row_type      reset_steps[NUM_STEPS];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                no_stall = 1'b0;
   bit                hold_off_req = 1'b0;

   length_prefix_deframer_keepalive u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void deframe_next(input lpdk_pkg::req_type item, output bit has,
                                        output lpdk_pkg::rsp_type result);
      logic [lpdk_pkg::LEN_WIDTH-1:0] len;
      has = 1'b0;
      result = NO_RSP;
      if (link_down) return;
      case (item.opcode)
         lpdk_pkg::OP_RX_BYTE: begin
            idle_count = '0;
            case (rx_phase)
               lpdk_pkg::PH_LEN_HI: begin
                  len_high_byte = item.rx_byte;
                  rx_phase = lpdk_pkg::PH_LEN_LO;
               end
               lpdk_pkg::PH_LEN_LO: begin
                  len = {len_high_byte, item.rx_byte};
                  if ({2'b00, len} + 18'd2 > {1'b0, cap_reg}) begin
                     link_down = 1'b1;
                     rx_phase = lpdk_pkg::PH_LEN_HI;
                     has = 1'b1;
                     result = '{lpdk_pkg::KIND_OVERSIZE, 8'd0, 1'b0, len};
                  end else if (len == '0) begin
                     rx_phase = lpdk_pkg::PH_CTRL;
                  end else begin
                     cur_frame_len = len;
                     body_left = len;
                     rx_phase = lpdk_pkg::PH_BODY;
                  end
               end
               lpdk_pkg::PH_CTRL: begin
                  rx_phase = lpdk_pkg::PH_LEN_HI;
                  if (item.rx_byte == ping_reg) begin
                     send_count = '0;
                     has = 1'b1;
                     result = '{lpdk_pkg::KIND_PONG, pong_reg, 1'b0, 16'd0};
                  end
               end
               default: begin
                  body_left = body_left - 1'b1;
                  has = 1'b1;
                  result = '{lpdk_pkg::KIND_PAYLOAD, item.rx_byte, body_left == '0,
                             cur_frame_len};
                  if (body_left == '0) rx_phase = lpdk_pkg::PH_LEN_HI;
               end
            endcase
         end
         lpdk_pkg::OP_TICK: begin
            if (idle_count != '1) idle_count = idle_count + 1'b1;
            if (send_count != '1) send_count = send_count + 1'b1;
            if (idle_limit_reg != '0 && idle_count > idle_limit_reg) begin
               link_down = 1'b1;
               has = 1'b1;
               result = '{lpdk_pkg::KIND_IDLE, 8'd0, 1'b0, 16'd0};
            end else if (keepalive_limit_reg != '0 && send_count > keepalive_limit_reg) begin
               send_count = '0;
               has = 1'b1;
               result = '{lpdk_pkg::KIND_PING, ping_reg, 1'b0, 16'd0};
            end
         end
         lpdk_pkg::OP_SENT: send_count = '0;
         default: ;
      endcase
   endfunction

   function automatic lpdk_pkg::req_type next_stream_item(input gen_mode_type mode);
      lpdk_pkg::req_type item;
      int unsigned       pick;
      int unsigned       room;
      int unsigned       upper;
      item.opcode = lpdk_pkg::OP_RX_BYTE;
      item.rx_byte = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (mode == GEN_CLOSE_IDLE) begin
         item.opcode = lpdk_pkg::OP_TICK;
         return item;
      end
      if (mode == GEN_NORMAL) begin
         if (pick < 12) begin
            if (!(idle_limit_reg != '0 && {1'b0, idle_count} + 33'd1 > {1'b0, idle_limit_reg}))
               item.opcode = lpdk_pkg::OP_TICK;
         end else if (pick < 20) begin
            item.opcode = lpdk_pkg::OP_SENT;
         end else if (pick < 23) begin
            item.opcode = OP_UNUSED;
         end
      end
      if (item.opcode == lpdk_pkg::OP_RX_BYTE) begin
         case (rx_phase)
            lpdk_pkg::PH_LEN_HI: begin
               if (mode == GEN_CLOSE_OVERSIZE) begin
                  if (cap_reg < 2) plan_len = 16'($urandom);
                  else plan_len = 16'($urandom_range(cap_reg - 1, 65535));
               end else begin
                  room = cap_reg - 2;
                  upper = ($urandom_range(0, 39) == 0) ? 300 : 12;
                  if (room < upper) upper = room;
                  if (upper == 0 || $urandom_range(0, 3) == 0) plan_len = '0;
                  else if ($urandom_range(0, 7) == 0) plan_len = 16'(upper);
                  else plan_len = 16'($urandom_range(1, upper));
               end
               item.rx_byte = plan_len[15:8];
            end
            lpdk_pkg::PH_LEN_LO: item.rx_byte = plan_len[7:0];
            lpdk_pkg::PH_CTRL:   if ($urandom_range(0, 1) == 1) item.rx_byte = ping_reg;
            default: ;
         endcase
      end
      return item;
   endfunction

   task automatic offer(input lpdk_pkg::req_type item, input bit fixed, input bit fixed_has,
                        input lpdk_pkg::rsp_type fixed_rsp);
      int unsigned       gap;
      bit                has;
      lpdk_pkg::rsp_type result;
      gap = no_stall ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      deframe_next(item, has, result);
      if (fixed) begin
         has = fixed_has;
         result = fixed_rsp;
      end
      if (has) awaited_outputs.insert(awaited_outputs.size(), result);
   endtask

   task automatic write_csr(input logic [lpdk_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [lpdk_pkg::CSR_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lpdk_pkg::CSR_BUFFER_CAPACITY: cap_reg = value[lpdk_pkg::CAP_WIDTH-1:0];
         lpdk_pkg::CSR_PING_CODE:       ping_reg = value[lpdk_pkg::CODE_WIDTH-1:0];
         lpdk_pkg::CSR_PONG_CODE:       pong_reg = value[lpdk_pkg::CODE_WIDTH-1:0];
         lpdk_pkg::CSR_IDLE_LIMIT:      idle_limit_reg = value;
         lpdk_pkg::CSR_KEEPALIVE_LIMIT: keepalive_limit_reg = value;
         default: ;
      endcase
   endtask

   task automatic program_phase(input logic [lpdk_pkg::CSR_WIDTH-1:0] cap,
                                input logic [7:0] ping, input logic [7:0] pong,
                                input logic [lpdk_pkg::CSR_WIDTH-1:0] idle,
                                input logic [lpdk_pkg::CSR_WIDTH-1:0] keep);
      write_csr(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
      write_csr(lpdk_pkg::CSR_BUFFER_CAPACITY, cap);
      write_csr(lpdk_pkg::CSR_PING_CODE, {24'($urandom), ping});
      write_csr(lpdk_pkg::CSR_PONG_CODE, {24'($urandom), pong});
      write_csr(lpdk_pkg::CSR_IDLE_LIMIT, idle);
      write_csr(lpdk_pkg::CSR_KEEPALIVE_LIMIT, keep);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [lpdk_pkg::CSR_WIDTH-1:0] pick_limit(input int unsigned small_max);
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return $urandom_range(1, small_max);
         default: return $urandom;
      endcase
   endfunction

   initial begin : rsp_side
      int unsigned pause;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pause = no_stall ? 0 : $urandom_range(0, 5);
            if (pause != 0) begin
               rsp_ready <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      lpdk_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outputs.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer kind %0d byte %02h",
                                    rsp_data.out_kind, rsp_data.out_byte));
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_data.out_kind !== want.out_kind)
               flag_mismatch($sformatf("out_kind %0d, want %0d",
                                       rsp_data.out_kind, want.out_kind));
            if (rsp_data.out_byte !== want.out_byte)
               flag_mismatch($sformatf("out_byte %02h, want %02h",
                                       rsp_data.out_byte, want.out_byte));
            if (rsp_data.frame_last !== want.frame_last)
               flag_mismatch($sformatf("frame_last %0b, want %0b",
                                       rsp_data.frame_last, want.frame_last));
            if (rsp_data.frame_length !== want.frame_length)
               flag_mismatch($sformatf("frame_length %0d, want %0d",
                                       rsp_data.frame_length, want.frame_length));
         end
      end
   end

   initial begin : req_side
      int unsigned                    count;
      gen_mode_type                   close_mode;
      logic [lpdk_pkg::CSR_WIDTH-1:0] cap_val;
      lpdk_pkg::req_type              raw;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      cap_reg = lpdk_pkg::CAP_RESET;
      ping_reg = lpdk_pkg::PING_RESET;
      pong_reg = lpdk_pkg::PONG_RESET;
      idle_limit_reg = lpdk_pkg::LIMIT_RESET;
      keepalive_limit_reg = lpdk_pkg::LIMIT_RESET;
      rx_phase = lpdk_pkg::PH_LEN_HI;
      len_high_byte = '0;
      cur_frame_len = '0;
      body_left = '0;
      link_down = 1'b0;
      idle_count = '0;
      send_count = '0;
      plan_len = '0;

      reset_steps = '{
         '{'{lpdk_pkg::OP_TICK,    8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_SENT,    8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{OP_UNUSED,            8'hFF}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h01}, 1'b1, 1'b1,
           '{lpdk_pkg::KIND_PONG, lpdk_pkg::PONG_RESET, 1'b0, 16'd0}},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'hFE}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h01}, 1'b1, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'hFF}, 1'b1, 1'b1,
           '{lpdk_pkg::KIND_PAYLOAD, 8'hFF, 1'b1, 16'd1}},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h03}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'hAA}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h55}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h00}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h02}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h80}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_TICK,    8'h00}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_SENT,    8'h00}, 1'b0, 1'b0, NO_RSP},
         '{'{lpdk_pkg::OP_RX_BYTE, 8'h7F}, 1'b0, 1'b0, NO_RSP}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (reset_steps[i])
         offer(reset_steps[i].item, reset_steps[i].fixed, reset_steps[i].fixed_has,
               reset_steps[i].fixed_rsp);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         no_stall = (p == 2);
         case (p)
            0: program_phase(32'd2, 8'h00, 8'hFF, '0, 32'd1);
            1: begin
               program_phase(32'd65537, 8'hFF, 8'h00, '1, '1);
               hold_off_req = 1'b1;
            end
            2: program_phase($urandom_range(2, 300), 8'($urandom), 8'($urandom),
                             $urandom_range(1, 8), $urandom_range(0, 6));
            default: begin
               case ($urandom_range(0, 2))
                  0:       cap_val = $urandom_range(2, 40);
                  1:       cap_val = {15'd0, lpdk_pkg::CAP_RESET};
                  default: begin
                     cap_val = $urandom;
                     if (cap_val[lpdk_pkg::CAP_WIDTH-1:0] < 2) cap_val[1] = 1'b1;
                  end
               endcase
               program_phase(cap_val, 8'($urandom), 8'($urandom),
                             pick_limit(8), pick_limit(6));
            end
         endcase
         count = 0;
         // finish the open frame so the next settings start on a length
         while (count < PHASE_ITEMS || rx_phase != lpdk_pkg::PH_LEN_HI) begin
            offer(next_stream_item(GEN_NORMAL), 1'b0, 1'b0, NO_RSP);
            count++;
         end
         drain();
      end

      // close the link once, then check that it stays silent
      no_stall = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
         close_mode = GEN_CLOSE_IDLE;
         program_phase({15'd0, cap_reg}, 8'($urandom), 8'($urandom), 32'd1,
                       $urandom_range(0, 2));
      end else begin
         close_mode = GEN_CLOSE_OVERSIZE;
         case ($urandom_range(0, 3))
            0:       cap_val = 32'd0;
            1:       cap_val = 32'd1;
            default: cap_val = $urandom_range(2, 65536);
         endcase
         program_phase(cap_val, 8'($urandom), 8'($urandom), '0, '0);
      end
      while (!link_down) offer(next_stream_item(close_mode), 1'b0, 1'b0, NO_RSP);
      repeat (12) begin
         raw.opcode = 2'($urandom);
         raw.rx_byte = 8'($urandom);
         offer(raw, 1'b0, 1'b0, NO_RSP);
      end
      drain();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: length_prefix_deframer_keepalive.f
design/lpdk_pkg.sv
design/length_prefix_deframer_keepalive.sv
verif/length_prefix_deframer_keepalive_tb.sv
